### rtl/core/rwlm_pkg.sv
// Shared types and codes for the reader-writer lock manager.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rwlm_pkg;

    // Request commands
    typedef enum logic [2:0] {
        CMD_RDLOCK    = 3'd0,
        CMD_TRYRDLOCK = 3'd1,
        CMD_RDUNLOCK  = 3'd2,
        CMD_WRLOCK    = 3'd3,
        CMD_TRYWRLOCK = 3'd4,
        CMD_WRUNLOCK  = 3'd5,
        CMD_UPGRADE   = 3'd6,
        CMD_DOWNGRADE = 3'd7
    } cmd_t;

    // Result status codes
    localparam logic [2:0] ST_GRANTED = 3'd0;
    localparam logic [2:0] ST_QUEUED  = 3'd1;
    localparam logic [2:0] ST_REFUSED = 3'd2;
    localparam logic [2:0] ST_MISUSE  = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    // Result item kinds
    localparam logic KIND_RESPONSE = 1'b0;
    localparam logic KIND_WAKEUP   = 1'b1;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECIDE = 5'b00010,
        S_RD     = 5'b00100,
        S_EMIT   = 5'b01000,
        S_UPG    = 5'b10000
    } state_t;

endpackage

`default_nettype wire

### rtl/core/reader_writer_lock_manager.sv
// Reader-writer lock manager: reader slots, FIFO wait queues, sequencer.
// Depends on rwlm_pkg.
`timescale 1ns / 1ps
`default_nettype none

//  channel | dir | tdata (low bit up)                              | tuser      | tlast
//  s_      | in  | cmd[2:0], thread_id[10:3], zero pad to 16       | -          | -
//  m_      | out | target_thread[7:0], status[10:8], grant_write  | item_kind  | last of request
//
//  A request is taken only in idle; its response is decided in S_DECIDE and presented once
//  the output register is free. Each reader or writer wakeup grant that follows passes through
//  a wait queue memory read (S_RD), then emit (S_EMIT); an upgrade grant is emitted from S_UPG.
//  A stalled output holds the sequencer in place; nothing is dropped.
//  Synchronous active-low reset empties the slots and queues; no clearing pass.
module reader_writer_lock_manager #(
    parameter int READER_SLOTS      = 16,
    parameter int READ_QUEUE_DEPTH  = 64,
    parameter int WRITE_QUEUE_DEPTH = 16,
    parameter int THREAD_BITS       = 8
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // cmd[2:0], thread_id[10:3], pad
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // target_thread[7:0], status[10:8], grant_write[11], pad
    output logic        m_tuser,   // item_kind
    output logic        m_tlast
);
    import rwlm_pkg::*;

    localparam int NS  = READER_SLOTS;
    localparam int RAW = $clog2(READ_QUEUE_DEPTH);
    localparam int WAW = $clog2(WRITE_QUEUE_DEPTH);
    localparam int TB  = THREAD_BITS;

    state_t state_reg;

    cmd_t            cmd_reg;
    logic [TB-1:0]   tid_reg;
    logic [TB-1:0]   slots_reg [NS];
    logic [TB-1:0]   aw_reg, pu_reg;
    logic [RAW-1:0]  rhead_reg;
    logic [RAW:0]    rcnt_reg;
    logic [WAW-1:0]  whead_reg;
    logic [WAW:0]    wcnt_reg;
    logic [NS-1:0]   elig_reg;

    logic [TB-1:0]   rq_mem [READ_QUEUE_DEPTH];
    logic [TB-1:0]   wq_mem [WRITE_QUEUE_DEPTH];
    logic [TB-1:0]   rq_rdata_reg, wq_rdata_reg;

    logic            mvalid_reg, mkind_reg, mlast_reg, mwr_reg;
    logic [TB-1:0]   mtgt_reg;
    logic [2:0]      mst_reg;

    logic [23:0]     tid_ext, tgt_ext;
    logic            out_free;
    logic            m_load;

    // Map the 8-bit thread field onto THREAD_BITS
    assign tid_ext = {16'd0, s_tdata[10:3]};
    assign tgt_ext = {{(24 - TB){1'b0}}, mtgt_reg};

    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !mvalid_reg || m_tready;
    assign m_load   = out_free &&
                      (state_reg == S_DECIDE || state_reg == S_EMIT || state_reg == S_UPG);
    assign m_tvalid = mvalid_reg;
    assign m_tuser  = mkind_reg;
    assign m_tlast  = mlast_reg;
    assign m_tdata  = {4'd0, mwr_reg, mst_reg, tgt_ext[7:0]};

    // Slot search: matches and free entries, lowest one first
    logic [NS-1:0] hit, empty, si_oh, fi_oh, e_oh, elig_rest;
    logic in_slot, is_writer, holds, any_reader, any_other, has_free;
    always_comb begin
        for (int i = 0; i < NS; i++) begin
            hit[i]   = (slots_reg[i] == tid_reg);
            empty[i] = (slots_reg[i] == '0);
        end
    end
    assign si_oh      = hit & (~hit + 1'b1);
    assign fi_oh      = empty & (~empty + 1'b1);
    assign e_oh       = elig_reg & (~elig_reg + 1'b1);
    assign elig_rest  = elig_reg & ~e_oh;
    assign in_slot    = (tid_reg != '0) && (|hit);
    assign is_writer  = (tid_reg != '0) && (tid_reg == aw_reg);
    assign holds      = in_slot || is_writer || ((tid_reg != '0) && (tid_reg == pu_reg));
    assign any_reader = |(~empty);
    assign any_other  = |(~empty & ~si_oh);
    assign has_free   = |empty;

    // Decide the response and the follow-up work for one request
    logic [2:0]    d_st;
    logic          d_wr, a_setfree, a_enqr, a_enqw, a_clrsi, a_setaw, a_clraw;
    logic          a_setpu, a_slot0;
    state_t        d_nxt;
    logic [NS-1:0] d_elig;
    always_comb begin
        d_st = ST_MISUSE; d_wr = 1'b0; d_nxt = S_IDLE; d_elig = '0;
        a_setfree = 1'b0; a_enqr = 1'b0; a_enqw = 1'b0; a_clrsi = 1'b0;
        a_setaw = 1'b0; a_clraw = 1'b0; a_setpu = 1'b0; a_slot0 = 1'b0;
        if (tid_reg != '0) begin
            unique case (cmd_reg)
                CMD_RDLOCK, CMD_TRYRDLOCK: begin
                    if (holds) begin
                        d_st = ST_MISUSE;
                    end else if (rcnt_reg == '0 && aw_reg == '0 && pu_reg == '0 && has_free) begin
                        d_st = ST_GRANTED; a_setfree = 1'b1;
                    end else if (cmd_reg == CMD_TRYRDLOCK) begin
                        d_st = ST_REFUSED;
                    end else if (rcnt_reg[RAW]) begin
                        d_st = ST_FULL;
                    end else begin
                        d_st = ST_QUEUED; a_enqr = 1'b1;
                    end
                end
                CMD_RDUNLOCK: begin
                    if (in_slot && !is_writer) begin
                        d_st = ST_GRANTED; a_clrsi = 1'b1; d_elig = si_oh;
                        if (pu_reg != '0) begin
                            if (!any_other) d_nxt = S_UPG;
                        end else if (wcnt_reg != '0) begin
                            if (!any_other) d_nxt = S_RD;
                        end else if (rcnt_reg != '0) begin
                            d_nxt = S_RD;
                        end
                    end
                end
                CMD_WRLOCK, CMD_TRYWRLOCK: begin
                    if (holds) begin
                        d_st = ST_MISUSE;
                    end else if (rcnt_reg == '0 && aw_reg == '0 && pu_reg == '0 && !any_reader) begin
                        d_st = ST_GRANTED; d_wr = 1'b1; a_setaw = 1'b1;
                    end else if (cmd_reg == CMD_TRYWRLOCK) begin
                        d_st = ST_REFUSED;
                    end else if (wcnt_reg[WAW]) begin
                        d_st = ST_FULL;
                    end else begin
                        d_st = ST_QUEUED; a_enqw = 1'b1;
                    end
                end
                CMD_WRUNLOCK: begin
                    if (is_writer && !in_slot) begin
                        d_st = ST_GRANTED; a_clraw = 1'b1; d_elig = empty;
                        if (wcnt_reg != '0) begin
                            if (!any_reader) d_nxt = S_RD;
                        end else if (rcnt_reg != '0 && has_free) begin
                            d_nxt = S_RD;
                        end
                    end
                end
                CMD_UPGRADE: begin
                    if (!in_slot || is_writer) begin
                        d_st = ST_MISUSE;
                    end else if (pu_reg != '0) begin
                        d_st = ST_REFUSED;
                    end else begin
                        a_clrsi = 1'b1;
                        if (any_other) begin
                            d_st = ST_QUEUED; a_setpu = 1'b1;
                        end else begin
                            d_st = ST_GRANTED; d_wr = 1'b1; a_setaw = 1'b1;
                        end
                    end
                end
                CMD_DOWNGRADE: begin
                    if (is_writer && !in_slot && !any_reader) begin
                        d_st = ST_GRANTED; a_clraw = 1'b1; a_slot0 = 1'b1;
                        d_elig = empty & ~(NS'(1));
                        if (wcnt_reg == '0 && rcnt_reg != '0 && (|d_elig)) d_nxt = S_RD;
                    end
                end
                default: d_st = ST_MISUSE;
            endcase
        end
    end

    // Wait queue memories: write at tail, read head every cycle
    always_ff @(posedge aclk) begin
        if (state_reg == S_DECIDE && out_free && a_enqr)
            rq_mem[rhead_reg + rcnt_reg[RAW-1:0]] <= tid_reg;
        rq_rdata_reg <= rq_mem[rhead_reg];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_DECIDE && out_free && a_enqw)
            wq_mem[whead_reg + wcnt_reg[WAW-1:0]] <= tid_reg;
        wq_rdata_reg <= wq_mem[whead_reg];
    end

    // Sequencer, lock state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            aw_reg     <= '0;
            pu_reg     <= '0;
            rhead_reg  <= '0;
            rcnt_reg   <= '0;
            whead_reg  <= '0;
            wcnt_reg   <= '0;
            mvalid_reg <= 1'b0;
            for (int i = 0; i < NS; i++) slots_reg[i] <= '0;
        end else begin
            // Load a new item when the register is free, drop it once taken
            if (m_load) mvalid_reg <= 1'b1;
            else if (m_tready) mvalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg   <= cmd_t'(s_tdata[2:0]);
                        tid_reg   <= tid_ext[TB-1:0];
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (out_free) begin
                        mkind_reg  <= KIND_RESPONSE;
                        mtgt_reg   <= tid_reg;
                        mst_reg    <= d_st;
                        mwr_reg    <= d_wr;
                        mlast_reg  <= (d_nxt == S_IDLE);
                        elig_reg   <= d_elig;
                        state_reg  <= d_nxt;
                        for (int i = 0; i < NS; i++) begin
                            if (a_setfree && fi_oh[i]) slots_reg[i] <= tid_reg;
                            if (a_clrsi && si_oh[i]) slots_reg[i] <= '0;
                        end
                        if (a_slot0) slots_reg[0] <= tid_reg;
                        if (a_enqr) rcnt_reg <= rcnt_reg + 1'b1;
                        if (a_enqw) wcnt_reg <= wcnt_reg + 1'b1;
                        if (a_setaw) aw_reg <= tid_reg;
                        if (a_clraw) aw_reg <= '0;
                        if (a_setpu) pu_reg <= tid_reg;
                    end
                end
                S_RD: state_reg <= S_EMIT;
                S_EMIT: begin
                    if (out_free) begin
                        mkind_reg  <= KIND_WAKEUP;
                        mst_reg    <= ST_GRANTED;
                        if (wcnt_reg != '0) begin
                            // hand the lock to the oldest waiting writer
                            aw_reg    <= wq_rdata_reg;
                            mtgt_reg  <= wq_rdata_reg;
                            mwr_reg   <= 1'b1;
                            mlast_reg <= 1'b1;
                            whead_reg <= whead_reg + 1'b1;
                            wcnt_reg  <= wcnt_reg - 1'b1;
                            state_reg <= S_IDLE;
                        end else begin
                            // place the oldest waiting reader in the lowest eligible free slot
                            for (int i = 0; i < NS; i++)
                                if (e_oh[i]) slots_reg[i] <= rq_rdata_reg;
                            mtgt_reg  <= rq_rdata_reg;
                            mwr_reg   <= 1'b0;
                            mlast_reg <= (rcnt_reg == 1) || (elig_rest == '0);
                            rhead_reg <= rhead_reg + 1'b1;
                            rcnt_reg  <= rcnt_reg - 1'b1;
                            elig_reg  <= elig_rest;
                            state_reg <= ((rcnt_reg == 1) || (elig_rest == '0)) ? S_IDLE : S_RD;
                        end
                    end
                end
                S_UPG: begin
                    if (out_free) begin
                        mkind_reg  <= KIND_WAKEUP;
                        mtgt_reg   <= pu_reg;
                        mst_reg    <= ST_GRANTED;
                        mwr_reg    <= 1'b1;
                        mlast_reg  <= 1'b1;
                        aw_reg     <= pu_reg;
                        pu_reg     <= '0;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Checks on lock state and result ordering
    a_rq_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rcnt_reg <= READ_QUEUE_DEPTH)
        else $error("read queue count beyond depth");
    a_wq_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wcnt_reg <= WRITE_QUEUE_DEPTH)
        else $error("write queue count beyond depth");
    a_owner_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(aw_reg != '0 && pu_reg != '0))
        else $error("writer and pending upgrader both set");
    a_wgrant_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (mvalid_reg && mkind_reg == KIND_WAKEUP && mwr_reg) |-> mlast_reg)
        else $error("writer wakeup not last item");
    a_idle_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && mvalid_reg) |-> mlast_reg)
        else $error("idle with unfinished request");

endmodule

`default_nettype wire
